[hw/rtl/cartesian_polar_converter_defines.svh]
// Assertion macros used by the checker file.
`ifndef CARTESIAN_POLAR_CONVERTER_DEFINES_SVH
`define CARTESIAN_POLAR_CONVERTER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define CPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define CPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define CPC_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cpc_pkg.sv]
`timescale 1ns / 1ps

package cpc_pkg;

    // Conversion select
    typedef enum logic {
        OP_TO_POLAR = 1'b0,
        OP_TO_CART  = 1'b1
    } t_op;

    // Default number of micro-rotations and the size of the arctangent table
    localparam int CPC_ROTATION_STEPS = 16;
    localparam int CPC_TABLE_LEN      = 24;

    // Internal formats: coordinates Q14, angles in 2^-32 turn
    localparam int CPC_CW = 32;
    localparam int CPC_ZW = 33;

    // Inverse CORDIC gain, Q30
    localparam longint CPC_GAIN_BASE = 64'sd652032874;

    // Exact axis angles, 65536 = full turn
    localparam logic [15:0] ANG_ZERO    = 16'd0;
    localparam logic [15:0] ANG_QUARTER = 16'd16384;
    localparam logic [15:0] ANG_HALF    = 16'd32768;
    localparam logic [15:0] ANG_3QUART  = 16'd49152;

    // round(atan(2^-i) / (2 pi) * 2^32)
    localparam logic [31:0] CPC_ARC_TABLE [0:CPC_TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // One pipeline slot of the rotation chain
    typedef struct packed {
        t_op                      mode;
        logic                     flip;     // negate result (back-facing angle)
        logic                     bypass;   // axis case, result known up front
        logic [15:0]              byp_rad;
        logic [15:0]              byp_ang;
        logic signed [CPC_CW-1:0] x;
        logic signed [CPC_CW-1:0] y;
        logic signed [CPC_ZW-1:0] z;
    } t_cord;

endpackage

[hw/rtl/cpc_prep.sv]
`timescale 1ns / 1ps

module cpc_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_op,
    input  logic signed [15:0]   i_x_in,
    input  logic signed [15:0]   i_y_in,
    input  logic [14:0]          i_radius_in,
    input  logic [15:0]          i_angle_in,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output cpc_pkg::t_cord       o_data
);
    import cpc_pkg::*;

    logic               r_valid;
    t_cord              r_data;
    t_cord              n_data;

    logic signed [16:0] x17;
    logic signed [16:0] y17;
    logic signed [16:0] xr;
    logic signed [16:0] yr;
    logic [15:0]        x_abs;
    logic [15:0]        y_abs;
    logic               a_flip;
    logic signed [15:0] a_adj;

    // Sign-extend so that negating -32768 stays exact
    assign x17   = {i_x_in[15], i_x_in};
    assign y17   = {i_y_in[15], i_y_in};
    assign x_abs = x17[16] ? 16'(-x17) : x17[15:0];
    assign y_abs = y17[16] ? 16'(-y17) : y17[15:0];

    // Left half plane: negate the vector, half turn added to the angle
    assign xr = x17[16] ? -x17 : x17;
    assign yr = x17[16] ? -y17 : y17;

    // Angles in [1/4, 3/4) turn rotate by a half turn; fold into [-1/4, 1/4)
    assign a_flip = i_angle_in[15] ^ i_angle_in[14];
    assign a_adj  = $signed({i_angle_in[15] ^ a_flip, i_angle_in[14:0]});

    // Initial vector and angle accumulator
    always_comb begin
        n_data         = '0;
        n_data.mode    = t_op'(i_op);
        if (t_op'(i_op) == OP_TO_POLAR) begin
            n_data.x = {xr[16], xr, 14'b0};
            n_data.y = {yr[16], yr, 14'b0};
            n_data.z = x17[16] ? 33'sh0_8000_0000 : 33'sh0;
            if (i_y_in == 16'sd0) begin
                n_data.bypass  = 1'b1;
                n_data.byp_rad = x_abs;
                n_data.byp_ang = x17[16] ? ANG_HALF : ANG_ZERO;
            end else if (i_x_in == 16'sd0) begin
                n_data.bypass  = 1'b1;
                n_data.byp_rad = y_abs;
                n_data.byp_ang = y17[16] ? ANG_3QUART : ANG_QUARTER;
            end
        end else begin
            n_data.flip = a_flip;
            n_data.x    = $signed({3'b0, i_radius_in, 14'b0});
            n_data.y    = '0;
            n_data.z    = {a_adj[15], a_adj, 16'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/cpc_stage.sv]
`timescale 1ns / 1ps

module cpc_stage #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cpc_pkg::t_cord i_data,
    input  logic           i_ready,
    output logic           o_ready,
    output logic           o_valid,
    output cpc_pkg::t_cord o_data
);
    import cpc_pkg::*;

    localparam logic signed [CPC_ZW-1:0] Arc = $signed({1'b0, CPC_ARC_TABLE[SHIFT]});

    logic                     r_valid;
    t_cord                    r_data;
    t_cord                    n_data;
    logic                     neg;
    logic signed [CPC_CW-1:0] x_sh;
    logic signed [CPC_CW-1:0] y_sh;

    // Vectoring drives y to zero, rotation drives z to zero
    assign neg  = (i_data.mode == OP_TO_POLAR) ? !i_data.y[CPC_CW-1] : i_data.z[CPC_ZW-1];
    assign x_sh = $signed(i_data.x) >>> SHIFT;
    assign y_sh = $signed(i_data.y) >>> SHIFT;

    // One micro-rotation
    always_comb begin
        n_data = i_data;
        if (neg) begin
            n_data.x = $signed(i_data.x) + y_sh;
            n_data.y = $signed(i_data.y) - x_sh;
            n_data.z = $signed(i_data.z) + Arc;
        end else begin
            n_data.x = $signed(i_data.x) - y_sh;
            n_data.y = $signed(i_data.y) + x_sh;
            n_data.z = $signed(i_data.z) - Arc;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/cpc_scale.sv]
`timescale 1ns / 1ps

module cpc_scale #(
    parameter int STEPS = cpc_pkg::CPC_ROTATION_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cpc_pkg::t_cord     i_data,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output logic signed [15:0] o_x_out,
    output logic signed [15:0] o_y_out,
    output logic [15:0]        o_radius_out,
    output logic [15:0]        o_angle_out
);
    import cpc_pkg::*;

    // Gain with the finite-step correction
    localparam longint GainCorr = (2 * CPC_GAIN_BASE) / (3 * (64'sd1 << (2 * STEPS)));
    localparam logic signed [30:0] Gain = 31'(CPC_GAIN_BASE + GainCorr);
    localparam logic signed [63:0] RoundHalf = 64'sd1 <<< 43;

    // Stage A: gain multiply
    logic               r_a_valid;
    t_op                r_a_mode;
    logic               r_a_flip;
    logic               r_a_bypass;
    logic [15:0]        r_a_byp_rad;
    logic [15:0]        r_a_byp_ang;
    logic [31:0]        r_a_z;
    logic signed [62:0] r_a_px;
    logic signed [62:0] r_a_py;
    logic signed [62:0] n_px;
    logic signed [62:0] n_py;
    logic               ready_a;

    // Stage B: rounding, saturation, output select
    logic               r_b_valid;
    logic signed [15:0] r_x_out;
    logic signed [15:0] r_y_out;
    logic [15:0]        r_radius_out;
    logic [15:0]        r_angle_out;
    logic               ready_b;

    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;
    logic signed [19:0] rx;
    logic signed [19:0] ry;
    logic signed [19:0] fx;
    logic signed [19:0] fy;
    logic [31:0]        z_rnd;
    logic signed [15:0] n_x_out;
    logic signed [15:0] n_y_out;
    logic [15:0]        n_radius_out;
    logic [15:0]        n_angle_out;

    assign n_px = $signed(i_data.x) * Gain;
    assign n_py = $signed(i_data.y) * Gain;

    assign ready_b = !r_b_valid || !i_stall;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_mode    <= i_data.mode;
            r_a_flip    <= i_data.flip;
            r_a_bypass  <= i_data.bypass;
            r_a_byp_rad <= i_data.byp_rad;
            r_a_byp_ang <= i_data.byp_ang;
            r_a_z       <= i_data.z[31:0];
            r_a_px      <= n_px;
            r_a_py      <= n_py;
        end
    end

    // Round half up, drop 44 fraction bits
    assign sum_x = $signed({r_a_px[62], r_a_px}) + RoundHalf;
    assign sum_y = $signed({r_a_py[62], r_a_py}) + RoundHalf;
    assign rx    = sum_x[63:44];
    assign ry    = sum_y[63:44];
    assign fx    = r_a_flip ? -rx : rx;
    assign fy    = r_a_flip ? -ry : ry;
    assign z_rnd = r_a_z + 32'h0000_8000;

    always_comb begin
        n_x_out      = '0;
        n_y_out      = '0;
        n_radius_out = '0;
        n_angle_out  = '0;
        if (r_a_mode == OP_TO_POLAR) begin
            if (r_a_bypass) begin
                n_radius_out = r_a_byp_rad;
                n_angle_out  = r_a_byp_ang;
            end else begin
                if (rx[19]) begin
                    n_radius_out = 16'd0;
                end else if (rx[18:16] != 3'd0) begin
                    n_radius_out = 16'hFFFF;
                end else begin
                    n_radius_out = rx[15:0];
                end
                n_angle_out = z_rnd[31:16];
            end
        end else begin
            // Saturate to signed 16 bits
            if (fx[19:15] != {5{fx[19]}}) begin
                n_x_out = fx[19] ? 16'sh8000 : 16'sh7FFF;
            end else begin
                n_x_out = fx[15:0];
            end
            if (fy[19:15] != {5{fy[19]}}) begin
                n_y_out = fy[19] ? 16'sh8000 : 16'sh7FFF;
            end else begin
                n_y_out = fy[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_x_out      <= n_x_out;
            r_y_out      <= n_y_out;
            r_radius_out <= n_radius_out;
            r_angle_out  <= n_angle_out;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_x_out      = r_x_out;
    assign o_y_out      = r_y_out;
    assign o_radius_out = r_radius_out;
    assign o_angle_out  = r_angle_out;

endmodule

[hw/rtl/cartesian_polar_converter.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// request  in         i_valid / o_stall    i_op, i_x_in, i_y_in, i_radius_in, i_angle_in
// result   out        o_valid / i_stall    o_x_out, o_y_out, o_radius_out, o_angle_out
//
// One transaction per cycle sustained while the result side does not stall; one
// register stage per CORDIC micro-rotation plus input prep, gain multiply and
// rounding/saturation stages.
// Synchronous active-low reset empties every stage; no clearing pass.
// A stall on the result side holds the output register; empty stages upstream
// keep filling, and o_stall rises only once every stage holds a transaction.

module cartesian_polar_converter #(
    parameter int ROTATION_STEPS = cpc_pkg::CPC_ROTATION_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic signed [15:0] i_x_in,
    input  logic signed [15:0] i_y_in,
    input  logic [14:0]        i_radius_in,
    input  logic [15:0]        i_angle_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_out,
    output logic signed [15:0] o_y_out,
    output logic [15:0]        o_radius_out,
    output logic [15:0]        o_angle_out
);
    import cpc_pkg::*;

    logic  w_valid [0:ROTATION_STEPS];
    logic  w_ready [0:ROTATION_STEPS+1];
    t_cord w_data  [0:ROTATION_STEPS];

    // Input prep: axis cases, half-plane fold, fixed-point scaling
    cpc_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_radius_in (i_radius_in),
        .i_angle_in  (i_angle_in),
        .i_ready     (w_ready[1]),
        .o_ready     (w_ready[0]),
        .o_valid     (w_valid[0]),
        .o_data      (w_data[0])
    );

    assign o_stall = !w_ready[0];

    // Micro-rotation chain
    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
        cpc_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .i_ready (w_ready[g+2]),
            .o_ready (w_ready[g+1]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Gain correction and output formatting
    cpc_scale #(
        .STEPS (ROTATION_STEPS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[ROTATION_STEPS]),
        .i_data       (w_data[ROTATION_STEPS]),
        .i_stall      (i_stall),
        .o_ready      (w_ready[ROTATION_STEPS+1]),
        .o_valid      (o_valid),
        .o_x_out      (o_x_out),
        .o_y_out      (o_y_out),
        .o_radius_out (o_radius_out),
        .o_angle_out  (o_angle_out)
    );

endmodule

[hw/rtl/cpc_checker.sv]
`timescale 1ns / 1ps
`include "cartesian_polar_converter_defines.svh"

module cpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_op,
    input logic signed [15:0] i_x_in,
    input logic signed [15:0] i_y_in,
    input logic [14:0]        i_radius_in,
    input logic [15:0]        i_angle_in,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_x_out,
    input logic signed [15:0] o_y_out,
    input logic [15:0]        o_radius_out,
    input logic [15:0]        o_angle_out
);

    logic [63:0] in_bus;
    logic [63:0] out_bus;
    logic        cart_zero;
    logic        polar_zero;

    // Flattened payloads and per-pair zero flags
    assign in_bus     = {i_op, i_x_in, i_y_in, i_radius_in, i_angle_in};
    assign out_bus    = {o_x_out, o_y_out, o_radius_out, o_angle_out};
    assign cart_zero  = (o_x_out == 16'sd0) && (o_y_out == 16'sd0);
    assign polar_zero = (o_radius_out == 16'd0) && (o_angle_out == 16'd0);

    // A stalled request holds
    `CPC_ASSERT_NXT(a_in_hold, i_valid && o_stall, i_valid && $stable(in_bus), "stalled request changed")

    // A stalled result holds
    `CPC_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_bus), "stalled result changed")

    // Backpressure only with a full pipeline behind a stalled result
    `CPC_ASSERT_IMP(a_stall_full, o_stall, o_valid && i_stall, "request stalled without stalled result")

    // Each result carries one conversion; the other pair is zero
    `CPC_ASSERT_IMP(a_mode_zero, o_valid, cart_zero || polar_zero, "both result pairs nonzero")

    // Reset empties the pipeline
    `CPC_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind cartesian_polar_converter cpc_checker u_cpc_checker (.*);

[sim/tb_cartesian_polar_converter.sv]
`timescale 1ns / 1ps

module tb_cartesian_polar_converter;

    localparam int ROT_STEPS    = 16;
    localparam int STEP_COUNT   = (ROT_STEPS > 24) ? 24 : ROT_STEPS;
    localparam int PIPE_LATENCY = ROT_STEPS + 3;
    localparam int HOLD_CYCLES  = 120;
    localparam longint GAIN_INV_Q30 = 64'sd652032874;

    typedef struct packed {
        cpc_pkg::t_op       op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        radius;
        logic [15:0]        angle;
    } t_conv_req;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        radius;
        logic [15:0]        angle;
    } t_conv_res;

    // Receiver back-pressure styles
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic signed [15:0] i_x_in;
    logic signed [15:0] i_y_in;
    logic [14:0]        i_radius_in;
    logic [15:0]        i_angle_in;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_x_out;
    logic signed [15:0] o_y_out;
    logic [15:0]        o_radius_out;
    logic [15:0]        o_angle_out;

    t_conv_res pending_results[$];
    int        mismatch_count = 0;
    int        hold_reqs = 0;

    // atan(2^-i) in units of 2^-32 turn
    longint arctan_lut [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    cartesian_polar_converter #(
        .ROTATION_STEPS(ROT_STEPS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_radius_in (i_radius_in),
        .i_angle_in  (i_angle_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_radius_out(o_radius_out),
        .o_angle_out (o_angle_out)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Inverse gain plus the finite-step correction
    function automatic longint cordic_gain();
        longint den;
        den = 3 * (longint'(1) <<< (2 * STEP_COUNT));
        return GAIN_INV_Q30 + (2 * GAIN_INV_Q30) / den;
    endfunction

    // Gain multiply, round half up, drop Q14 and Q30 fractions
    function automatic longint scale_round(longint v);
        return (v * cordic_gain() + (longint'(1) <<< 43)) >>> 44;
    endfunction

    function automatic logic [15:0] sat_s16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    // Vectoring: x,y to magnitude and full-circle angle
    function automatic t_conv_res predict_polar(longint xs, longint ys);
        t_conv_res res;
        longint x, y, z, dx, dy, mag, rounded;
        res = '0;
        // axis cases bypass the rotation chain
        if (ys == 0) begin
            res.radius = (xs < 0) ? 16'(-xs) : 16'(xs);
            res.angle  = (xs < 0) ? cpc_pkg::ANG_HALF : cpc_pkg::ANG_ZERO;
            return res;
        end
        if (xs == 0) begin
            res.radius = (ys < 0) ? 16'(-ys) : 16'(ys);
            res.angle  = (ys < 0) ? cpc_pkg::ANG_3QUART : cpc_pkg::ANG_QUARTER;
            return res;
        end
        x = xs;
        y = ys;
        z = 0;
        // left half plane: mirror through the origin, add a half turn
        if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(1) <<< 31;
        end
        x = x <<< 14;
        y = y <<< 14;
        for (int i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += arctan_lut[i];
            end else begin
                x -= dx;
                y += dy;
                z -= arctan_lut[i];
            end
        end
        mag = scale_round(x);
        if (mag < 0)
            mag = 0;
        if (mag > 65535)
            mag = 65535;
        res.radius = 16'(mag);
        rounded    = z + 32768;
        res.angle  = rounded[31:16];
        return res;
    endfunction

    // Rotation: radius and angle to x,y
    function automatic t_conv_res predict_cartesian(longint radius, longint angle);
        t_conv_res res;
        longint x, y, z, a, dx, dy;
        logic flip;
        res  = '0;
        a    = angle;
        x    = radius <<< 14;
        y    = 0;
        flip = 1'b0;
        // back-facing angles: rotate by a half turn, negate afterwards
        if (a >= 16384 && a < 49152) begin
            flip = 1'b1;
            a    = a - 32768;
        end else if (a >= 49152) begin
            a = a - 65536;
        end
        z = a * 65536;
        for (int i = 0; i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_lut[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_lut[i];
            end
        end
        x = scale_round(x);
        y = scale_round(y);
        if (flip) begin
            x = -x;
            y = -y;
        end
        res.x = sat_s16(x);
        res.y = sat_s16(y);
        return res;
    endfunction

    function automatic t_conv_res predict_conversion(t_conv_req req);
        if (req.op == cpc_pkg::OP_TO_POLAR)
            return predict_polar(longint'(req.x), longint'(req.y));
        return predict_cartesian(longint'({1'b0, req.radius}),
                                 longint'({1'b0, req.angle}));
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Every accepted request transaction yields one expected result
    always @(posedge i_clk) begin
        t_conv_req req;
        if (i_rst_n && i_valid && !o_stall) begin
            req.op     = cpc_pkg::t_op'(i_op);
            req.x      = i_x_in;
            req.y      = i_y_in;
            req.radius = i_radius_in;
            req.angle  = i_angle_in;
            pending_results.push_back(predict_conversion(req));
        end
    end

    task automatic report_mismatch(string why, t_conv_res want, t_conv_res got);
        if (mismatch_count < 10)
            $display("[%0t] %s: exp x=%0d y=%0d r=%0d a=%0d, got x=%0d y=%0d r=%0d a=%0d",
                     $time, why, want.x, want.y, want.radius, want.angle,
                     got.x, got.y, got.radius, got.angle);
        mismatch_count++;
    endtask

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_conv_res want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.x      = o_x_out;
            got.y      = o_y_out;
            got.radius = o_radius_out;
            got.angle  = o_angle_out;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.x !== want.x || got.y !== want.y ||
                    got.radius !== want.radius || got.angle !== want.angle)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, with an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin : rx_stall_gen
        t_rx_mode mode;
        int       mode_left;
        int       phase;
        int       hold_left;
        int       hold_seen;
        i_stall   = 1'b0;
        mode      = RX_FREE;
        mode_left = 0;
        phase     = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FREE:     i_stall <= 1'b0;
                    RX_LIGHT:    i_stall <= ($urandom_range(0, 99) < 20);
                    RX_HEAVY:    i_stall <= ($urandom_range(0, 99) < 70);
                    RX_PERIODIC: i_stall <= ((phase % 7) < 3);
                    default:     i_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one request and hold it until the block takes it
    task automatic send_conversion(t_conv_req req);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_op        <= req.op;
        i_x_in      <= req.x;
        i_y_in      <= req.y;
        i_radius_in <= req.radius;
        i_angle_in  <= req.angle;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // Idle the request channel for a number of cycles, junk on the payload
    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_valid     <= 1'b0;
        i_op        <= 1'($urandom);
        i_x_in      <= 16'($urandom);
        i_y_in      <= 16'($urandom);
        i_radius_in <= 15'($urandom);
        i_angle_in  <= 16'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_conv_req polar_req(int x, int y);
        t_conv_req req;
        req.op     = cpc_pkg::OP_TO_POLAR;
        req.x      = 16'(x);
        req.y      = 16'(y);
        req.radius = 15'($urandom);
        req.angle  = 16'($urandom);
        return req;
    endfunction

    function automatic t_conv_req cart_req(int radius, int angle);
        t_conv_req req;
        req.op     = cpc_pkg::OP_TO_CART;
        req.x      = 16'($urandom);
        req.y      = 16'($urandom);
        req.radius = 15'(radius);
        req.angle  = 16'(angle);
        return req;
    endfunction

    function automatic int pick_coord();
        int edges [6] = '{-32768, -32767, -1, 0, 1, 32767};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($signed(16'($urandom)));
            4:          return $urandom_range(0, 128) - 64;
            5:          return edges[$urandom_range(0, 5)];
            6:          return $urandom_range(0, 6) - 3;
            7:          return $urandom_range(30000, 32767) * ($urandom_range(0, 1) ? 1 : -1);
            default:    return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic t_conv_req random_request();
        int x, y, r, a;
        if ($urandom_range(0, 1) == 0) begin
            x = pick_coord();
            y = pick_coord();
            // land on an axis now and then
            case ($urandom_range(0, 7))
                0:       y = 0;
                1:       x = 0;
                default: ;
            endcase
            return polar_req(x, y);
        end
        case ($urandom_range(0, 7))
            0:       r = 0;
            1:       r = 32767;
            2:       r = $urandom_range(0, 64);
            default: r = $urandom_range(0, 32767);
        endcase
        // angles near the quadrant boundaries exercise the half-turn fold
        if ($urandom_range(0, 3) == 0)
            a = ($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3) & 16'hffff;
        else
            a = $urandom_range(0, 65535);
        return cart_req(r, a);
    endfunction

    // Random stream in bursts of random length with random gaps
    task automatic stream_random(int count);
        int burst_left;
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 60);
            end
            send_conversion(random_request());
            burst_left--;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Origin and the four axes, both signs and the extreme values
    task automatic test_axis_cases();
        send_conversion(polar_req(0, 0));
        send_conversion(polar_req(1234, 0));
        send_conversion(polar_req(-32768, 0));
        send_conversion(polar_req(0, 32767));
        send_conversion(polar_req(0, -32768));
        send_conversion(polar_req(-1, 0));
        send_conversion(polar_req(0, 1));
    endtask

    // Corners, left half plane, back-facing angles, saturation edges
    task automatic test_extremes();
        send_conversion(polar_req(32767, 32767));
        send_conversion(polar_req(-32768, -32768));
        send_conversion(polar_req(-32768, 32767));
        send_conversion(polar_req(32767, -32768));
        send_conversion(polar_req(-100, 50));
        send_conversion(polar_req(-100, -50));
        send_conversion(polar_req(100, -50));
        send_conversion(cart_req(0, 12345));
        send_conversion(cart_req(32767, 0));
        send_conversion(cart_req(32767, 16383));
        send_conversion(cart_req(32767, 16384));
        send_conversion(cart_req(32767, 32768));
        send_conversion(cart_req(32767, 49151));
        send_conversion(cart_req(32767, 49152));
        send_conversion(cart_req(32767, 65535));
        send_conversion(cart_req(1000, 8192));
        send_conversion(cart_req(1, 40000));
    endtask

    // Long receiver hold-off while the sender keeps offering transactions
    task automatic test_backpressure();
        pause_sender(2);
        hold_reqs++;
        for (int k = 0; k < 60; k++)
            send_conversion(random_request());
    endtask

    // Sender goes quiet until the pipeline has drained, then resumes
    task automatic test_drain_pause();
        for (int k = 0; k < 30; k++)
            send_conversion(random_request());
        pause_sender(1);
        wait_for_results();
        for (int k = 0; k < 30; k++)
            send_conversion(random_request());
    endtask

    task automatic test_random_stream();
        stream_random(900);
        pause_sender(3);
        hold_reqs++;
        stream_random(900);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = cpc_pkg::OP_TO_POLAR;
        i_x_in      = '0;
        i_y_in      = '0;
        i_radius_in = '0;
        i_angle_in  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_axis_cases();
        test_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_stream();

        pause_sender(1);
        wait_for_results();
        repeat (PIPE_LATENCY * 3) @(posedge i_clk);
        while (pending_results.size() != 0)
            report_mismatch("transaction never returned", pending_results.pop_front(), '0);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
